[sv/sdtt_pkg.sv]
// ============================================================================
// sdtt_pkg
// Shared types and constants of the step/direction target tracker.
// ============================================================================
package sdtt_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INTERVAL  = 3'd1,
    ST_AMBIGUOUS = 3'd2,
    ST_RATE      = 3'd3,
    ST_SATURATED = 3'd4
  } status_t;

  // Result event codes.
  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_ENABLED  = 2'd1,
    EV_DISABLED = 2'd2,
    EV_UPDATED  = 2'd3
  } event_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_STEPS_PER_REV = 2'd0;
  localparam logic [1:0] REG_MAX_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_MAX_RATE      = 2'd2;

  // Register reset values.
  localparam logic [15:0] STEPS_PER_REV_RST = 16'd3200;
  localparam logic [31:0] MAX_INTERVAL_RST  = 32'd100000;
  localparam logic [21:0] MAX_RATE_RST      = 22'd200000;

  // Microseconds per second, used by the plausibility check.
  localparam logic [19:0] US_PER_S = 20'd1000000;

  // Saturation limits of the 32-bit target.
  localparam logic [31:0] TARGET_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] TARGET_MIN = 32'h8000_0000;

  // Ambiguous wrapped step delta.
  localparam logic [31:0] DELTA_HALF = 32'h8000_0000;

  // How a word is closed out.
  typedef enum logic [1:0] {
    FIN_NONE   = 2'd0,
    FIN_RESYNC = 2'd1,
    FIN_REJECT = 2'd2,
    FIN_UPDATE = 2'd3
  } fin_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input word
    logic diff;       // register elapsed time and raw step delta
    logic mul;        // register magnitude and rate products
    logic div_start;  // load the divider
    logic div_step;   // one quotient bit
    fin_t fin;        // close out the word and load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic resync;     // seeding, enable edge or disabled sample
    logic reject;     // interval, ambiguity or rate check failed
    logic div_done;   // all quotient bits produced
    logic out_free;   // output register can take a word this cycle
  } stat_t;

endpackage

[sv/step_dir_target_tracker_top.sv]
// ============================================================================
// step_dir_target_tracker_top
// Step/direction target tracker: follows a wrapping step counter and keeps a
// signed fixed-point target position in revolutions.
// ============================================================================
// Each input word carries a wrapping 32-bit step count, the drive enable
// level, a wrapping microsecond timestamp and the measured position, and
// produces exactly one result word. The first word seeds the state; an
// enable edge or any word taken while disabled resyncs the target to the
// measured position and reports the event. While enabled, a word is
// rejected with state unchanged when the elapsed time is zero or beyond
// max_interval_us, when the wrapped delta is exactly half the counter range,
// or when (|delta|-1) * 10^6 exceeds max_rate_steps_per_s * elapsed;
// otherwise the target moves by trunc(delta * 2^FRAC_BITS / steps_per_rev)
// and saturates, flagged, at the 32-bit limits. The block handles one word
// at a time. A resync or rejected word closes out from the check state,
// after the difference and product registers; an update first passes the
// restoring divider (one quotient bit per cycle) and closes out from the
// apply state. A word meeting a stalled output waits in its final state
// until the output register frees up. Configuration must be written through
// cfg_we, cfg_index and cfg_data while the block is idle (not enforced).
module step_dir_target_tracker_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] step_count,
  input  logic               enable,
  input  logic [31:0]        time_us,
  input  logic signed [31:0] present_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [1:0]         event_res,
  output logic signed [31:0] target_position,
  output logic signed [31:0] step_delta
);
  import sdtt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // The controller sequences each word through the datapath.
  sdtt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // The datapath holds configuration, tracking state and the result register.
  sdtt_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .step_count       (step_count),
    .enable           (enable),
    .time_us          (time_us),
    .present_position (present_position),
    .cmd              (cmd),
    .st               (st),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .event_res        (event_res),
    .target_position  (target_position),
    .step_delta       (step_delta)
  );

  // An accepted word keeps the input stalled in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted word");

  // A word is never closed out over a pending result.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.fin != FIN_NONE) |-> st.out_free)
    else $error("result register overwritten while stalled");

  // Only an update reports a nonzero step delta.
  a_delta_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_UPDATED) |-> (step_delta == 32'sd0))
    else $error("step delta reported without an update");

  // Saturation can only come with an actual target update.
  a_sat_on_update: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SATURATED) |-> (event_res == EV_UPDATED))
    else $error("saturation reported without an update");

endmodule

[sv/sdtt_ctrl.sv]
// ============================================================================
// sdtt_ctrl
// Sequencer of the target tracker: accept, classify, divide, close out.
// ============================================================================
module sdtt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  sdtt_pkg::stat_t st,
  output sdtt_pkg::cmd_t  cmd
);
  import sdtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_APPLY
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.fin    = FIN_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // Resync and rejection close out here once the output is free.
        if (st.resync) begin
          if (st.out_free) begin
            cmd.fin    = FIN_RESYNC;
            state_next = S_IDLE;
          end
        end else if (st.reject) begin
          if (st.out_free) begin
            cmd.fin    = FIN_REJECT;
            state_next = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = S_APPLY;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_APPLY: begin
        if (st.out_free) begin
          cmd.fin    = FIN_UPDATE;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[sv/sdtt_dp.sv]
// ============================================================================
// sdtt_dp
// Datapath of the target tracker: configuration, tracking state, checks,
// restoring divider and saturating target update.
// ============================================================================
module sdtt_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic signed [31:0]    step_count,
  input  logic                  enable,
  input  logic [31:0]           time_us,
  input  logic signed [31:0]    present_position,
  input  sdtt_pkg::cmd_t        cmd,
  output sdtt_pkg::stat_t       st,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            status,
  output logic [1:0]            event_res,
  output logic signed [31:0]    target_position,
  output logic signed [31:0]    step_delta
);
  import sdtt_pkg::*;

  // The delta magnitude never exceeds 2^31-1 once accepted.
  localparam int MAG_W = 31;
  localparam int DW    = MAG_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DW + 1);
  localparam int SUM_W = DW + 2;

  // Configuration.
  logic [15:0] steps_per_rev;
  logic [31:0] max_interval_us;
  logic [21:0] max_rate_steps_per_s;

  // Tracking state.
  logic [31:0] prev_step_count;
  logic [31:0] prev_time;
  logic [31:0] target;
  logic        enabled_flag;
  logic        seeded;

  // Captured word.
  logic [31:0] cap_count;
  logic        cap_en;
  logic [31:0] cap_now;
  logic [31:0] cap_pos;

  // Check pipeline.
  logic [31:0]      elapsed;
  logic [31:0]      raw;
  logic [MAG_W-1:0] mag;
  logic             mag_nz;
  logic [50:0]      prod_a;
  logic [53:0]      prod_b;

  // Divider.
  logic [15:0]      divisor;
  logic [15:0]      rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] div_cnt;

  // Output register.
  status_t     status_r;
  event_t      event_r;
  logic [31:0] target_r;
  logic [31:0] delta_r;

  logic             interval_bad;
  logic             ambiguous;
  logic             rate_bad;
  logic [31:0]      mag_m1;
  logic [31:0]      mag_full;
  logic [16:0]      rem_sh;
  logic             rem_ge;
  logic [16:0]      rem_sub;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-32:0] sum_hi;
  logic             sat;
  logic [31:0]      sum_clamped;
  status_t          reject_code;
  event_t           resync_event;

  // Classification, read in the check cycle.
  assign interval_bad = (elapsed == 32'd0) || (elapsed > max_interval_us);
  assign ambiguous    = (raw == DELTA_HALF);
  assign rate_bad     = mag_nz && (prod_a > 51'(prod_b) || prod_b[53:51] != 3'd0 ? 
                        ({3'd0, prod_a} > prod_b) : 1'b0);

  assign st.resync   = !seeded || (cap_en != enabled_flag) || !cap_en;
  assign st.reject   = interval_bad || ambiguous || rate_bad;
  assign st.div_done = (div_cnt == '0);
  assign st.out_free = !out_valid || !out_stall;

  always_comb begin
    if (interval_bad) begin
      reject_code = ST_INTERVAL;
    end else if (ambiguous) begin
      reject_code = ST_AMBIGUOUS;
    end else begin
      reject_code = ST_RATE;
    end
    if (!seeded) begin
      resync_event = cap_en ? EV_ENABLED : EV_NONE;
    end else if (cap_en != enabled_flag) begin
      resync_event = cap_en ? EV_ENABLED : EV_DISABLED;
    end else begin
      resync_event = EV_NONE;
    end
  end

  // |delta| - 1 is ~raw for a negative delta and raw - 1 otherwise.
  assign mag_m1   = raw[31] ? ~raw : (raw - 32'd1);
  assign mag_full = raw[31] ? (32'd0 - raw) : raw;

  // One restoring division step.
  assign rem_sh  = {rem, quo[DW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor});
  assign rem_sub = rem_sh - {1'b0, divisor};

  // Saturating target update.
  assign sum = raw[31] ? ({{(SUM_W-32){target[31]}}, target} - {2'b00, quo})
                       : ({{(SUM_W-32){target[31]}}, target} + {2'b00, quo});
  assign sum_hi      = sum[SUM_W-1:31];
  assign sat         = !((&sum_hi) || !(|sum_hi));
  assign sum_clamped = sat ? (sum[SUM_W-1] ? TARGET_MIN : TARGET_MAX) : sum[31:0];

  // Configuration registers; writes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_rev        <= STEPS_PER_REV_RST;
      max_interval_us      <= MAX_INTERVAL_RST;
      max_rate_steps_per_s <= MAX_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEPS_PER_REV: steps_per_rev        <= cfg_data[15:0];
        REG_MAX_INTERVAL:  max_interval_us      <= cfg_data;
        REG_MAX_RATE:      max_rate_steps_per_s <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  // Tracking state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_step_count <= '0;
      prev_time       <= '0;
      target          <= '0;
      enabled_flag    <= 1'b0;
      seeded          <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      unique case (cmd.fin)
        FIN_RESYNC: begin
          prev_step_count <= cap_count;
          prev_time       <= cap_now;
          target          <= cap_pos;
          enabled_flag    <= cap_en;
          seeded          <= 1'b1;
        end
        FIN_UPDATE: begin
          prev_step_count <= cap_count;
          prev_time       <= cap_now;
          target          <= sum_clamped;
        end
        default: ;
      endcase
      if (cmd.fin != FIN_NONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cap_count <= step_count;
      cap_en    <= enable;
      cap_now   <= time_us;
      cap_pos   <= present_position;
    end
    if (cmd.diff) begin
      elapsed <= cap_now - prev_time;
      raw     <= cap_count - prev_step_count;
    end
    if (cmd.mul) begin
      mag    <= mag_full[MAG_W-1:0];
      mag_nz <= (raw != 32'd0);
      prod_a <= {20'd0, mag_m1[30:0]} * {31'd0, US_PER_S};
      prod_b <= {32'd0, max_rate_steps_per_s} * {22'd0, elapsed};
    end
    if (cmd.div_start) begin
      divisor <= (steps_per_rev == 16'd0) ? 16'd1 : steps_per_rev;
      rem     <= '0;
      quo     <= {mag, {FRAC_BITS{1'b0}}};
      div_cnt <= CNT_W'(DW);
    end else if (cmd.div_step) begin
      rem     <= rem_ge ? rem_sub[15:0] : rem_sh[15:0];
      quo     <= {quo[DW-2:0], rem_ge};
      div_cnt <= div_cnt - CNT_W'(1);
    end
    unique case (cmd.fin)
      FIN_RESYNC: begin
        status_r <= ST_OK;
        event_r  <= resync_event;
        target_r <= cap_pos;
        delta_r  <= '0;
      end
      FIN_REJECT: begin
        status_r <= reject_code;
        event_r  <= EV_NONE;
        target_r <= target;
        delta_r  <= '0;
      end
      FIN_UPDATE: begin
        status_r <= sat ? ST_SATURATED : ST_OK;
        event_r  <= (raw != 32'd0) ? EV_UPDATED : EV_NONE;
        target_r <= sum_clamped;
        delta_r  <= raw;
      end
      default: ;
    endcase
  end

  assign status          = status_r;
  assign event_res       = event_r;
  assign target_position = target_r;
  assign step_delta      = delta_r;

endmodule
